FILE: sv/tbcfs_pkg.sv
// Shared widths, register codes and queue entry type for the cull and shade block.
package tbcfs_pkg;

  // Fraction bits of the shade factor
  localparam int FRAC_BITS = 16;

  // Datapath widths
  localparam int XW  = 32;              // coordinate and color width
  localparam int EW  = 33;              // vertex difference
  localparam int PW  = 66;              // product of two differences
  localparam int CRW = 67;              // cross product component, signed
  localparam int AW  = 66;              // magnitude of a cross component
  localparam int HW  = 33;              // low half of a magnitude split
  localparam int SW  = 136;             // sum of squares of the normal
  localparam int DW  = 102;             // facing dot product, signed
  localparam int QW  = 2 * FRAC_BITS + 1; // quotient cz^2 * 2^2F / |c|^2
  localparam int RW  = FRAC_BITS + 1;   // shade factor, Q1.FRAC_BITS
  localparam int SQW = 2 * FRAC_BITS + 3; // running square in the root unit

  // Queue between front and back
  localparam int QDEPTH = 4;
  localparam int QAW    = 2;

  // Configuration register codes
  localparam int CFG_IW = 2;
  typedef enum logic [CFG_IW-1:0] {
    CFG_CAMERA_X = 2'd0,
    CFG_CAMERA_Y = 2'd1,
    CFG_CAMERA_Z = 2'd2
  } cfg_reg_t;

  // One classified triangle waiting for shading
  typedef struct packed {
    logic          vis;
    logic          shade;
    logic [SW-1:0] s;
    logic [SW-1:0] sz;
    logic [XW-1:0] color;
  } tbcfs_entry_t;

endpackage

FILE: sv/tbcfs_front.sv
// Front pipeline: edge vectors, cross product, normal length and facing test.
module tbcfs_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic signed [31:0]          in_v0_x,
  input  logic signed [31:0]          in_v0_y,
  input  logic signed [31:0]          in_v0_z,
  input  logic signed [31:0]          in_v1_x,
  input  logic signed [31:0]          in_v1_y,
  input  logic signed [31:0]          in_v1_z,
  input  logic signed [31:0]          in_v2_x,
  input  logic signed [31:0]          in_v2_y,
  input  logic signed [31:0]          in_v2_z,
  input  logic [31:0]                 in_face_color,
  input  logic signed [31:0]          cam_x,
  input  logic signed [31:0]          cam_y,
  input  logic signed [31:0]          cam_z,
  input  logic                        q_full,
  output logic                        q_push,
  output tbcfs_pkg::tbcfs_entry_t     q_entry
);

  localparam int EW  = tbcfs_pkg::EW;
  localparam int PW  = tbcfs_pkg::PW;
  localparam int CRW = tbcfs_pkg::CRW;
  localparam int AW  = tbcfs_pkg::AW;
  localparam int HW  = tbcfs_pkg::HW;
  localparam int SW  = tbcfs_pkg::SW;
  localparam int DW  = tbcfs_pkg::DW;
  localparam int XW  = tbcfs_pkg::XW;

  logic en;
  logic [4:0] vld_r;

  // Stage 1: differences
  logic signed [EW-1:0] e1_r [3];
  logic signed [EW-1:0] e2_r [3];
  logic signed [EW-1:0] d1_r [3];
  logic [XW-1:0]        col1_r;
  // Stage 2: products
  logic signed [PW-1:0] p_r [6];
  logic signed [EW-1:0] d2_r [3];
  logic [XW-1:0]        col2_r;
  // Stage 3: cross product
  logic signed [CRW-1:0] c_r [3];
  logic signed [EW-1:0]  d3_r [3];
  logic [XW-1:0]         col3_r;
  // Stage 4: partial products
  logic [PW-1:0]          hh_r [3];
  logic [PW-1:0]          hl_r [3];
  logic [PW-1:0]          ll_r [3];
  logic signed [CRW-1:0]  dh_r [3];
  logic signed [CRW-1:0]  dl_r [3];
  logic                   czn4_r;
  logic [XW-1:0]          col4_r;
  // Stage 5: sums
  logic [SW-1:0]          s_r;
  logic [SW-1:0]          sz_r;
  logic signed [DW-1:0]   dot_r;
  logic                   czn5_r;
  logic [XW-1:0]          col5_r;

  // Stage 4 and 5 combinational values
  logic [AW-1:0]          mag [3];
  logic [HW-1:0]          mh [3];
  logic [HW-1:0]          ml [3];
  logic signed [HW:0]     ch [3];
  logic signed [HW:0]     cl [3];
  logic [PW-1:0]          hh_nxt [3];
  logic [PW-1:0]          hl_nxt [3];
  logic [PW-1:0]          ll_nxt [3];
  logic signed [CRW-1:0]  dh_nxt [3];
  logic signed [CRW-1:0]  dl_nxt [3];
  logic [SW-1:0]          sq [3];
  logic [SW-1:0]          s_nxt;
  logic signed [DW-1:0]   dot_nxt;

  function automatic logic signed [EW-1:0] dif(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
    return EW'(a) - EW'(b);
  endfunction

  // Advance unless the last stage is blocked by a full queue
  assign en       = !(vld_r[4] && q_full);
  assign in_ready = en;
  assign q_push   = vld_r[4] && !q_full;

  // Split magnitudes and signed components into halves
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag[i]    = c_r[i][CRW-1] ? AW'(-c_r[i]) : AW'(c_r[i]);
      mh[i]     = mag[i][AW-1:HW];
      ml[i]     = mag[i][HW-1:0];
      ch[i]     = $signed(c_r[i][CRW-1:HW]);
      cl[i]     = $signed({1'b0, c_r[i][HW-1:0]});
      hh_nxt[i] = PW'(mh[i]) * PW'(mh[i]);
      hl_nxt[i] = PW'(mh[i]) * PW'(ml[i]);
      ll_nxt[i] = PW'(ml[i]) * PW'(ml[i]);
      dh_nxt[i] = ch[i] * d3_r[i];
      dl_nxt[i] = cl[i] * d3_r[i];
    end
  end

  // Sum the partial products into |c|^2 and the facing dot product
  always_comb begin
    s_nxt   = '0;
    dot_nxt = '0;
    for (int i = 0; i < 3; i++) begin
      sq[i]   = (SW'(hh_r[i]) << (2 * HW)) + (SW'(hl_r[i]) << (HW + 1)) + SW'(ll_r[i]);
      s_nxt   = s_nxt + sq[i];
      dot_nxt = dot_nxt + (DW'(dh_r[i]) <<< HW) + DW'(dl_r[i]);
    end
  end

  // Classify: flag zero normals and back-facing triangles as not visible
  always_comb begin
    q_entry.vis   = (s_r != '0) && (dot_r[DW-1] || (dot_r == '0));
    q_entry.shade = czn5_r;
    q_entry.s     = s_r;
    q_entry.sz    = sz_r;
    q_entry.color = col5_r;
  end

  // Valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[3:0], in_valid};
    end
  end

  // Payload stages
  always_ff @(posedge clk) begin
    if (en) begin
      e1_r[0] <= dif(in_v1_x, in_v0_x);
      e1_r[1] <= dif(in_v1_y, in_v0_y);
      e1_r[2] <= dif(in_v1_z, in_v0_z);
      e2_r[0] <= dif(in_v2_x, in_v0_x);
      e2_r[1] <= dif(in_v2_y, in_v0_y);
      e2_r[2] <= dif(in_v2_z, in_v0_z);
      d1_r[0] <= dif(in_v0_x, cam_x);
      d1_r[1] <= dif(in_v0_y, cam_y);
      d1_r[2] <= dif(in_v0_z, cam_z);
      col1_r  <= in_face_color;

      p_r[0] <= e1_r[1] * e2_r[2];
      p_r[1] <= e1_r[2] * e2_r[1];
      p_r[2] <= e1_r[2] * e2_r[0];
      p_r[3] <= e1_r[0] * e2_r[2];
      p_r[4] <= e1_r[0] * e2_r[1];
      p_r[5] <= e1_r[1] * e2_r[0];
      d2_r   <= d1_r;
      col2_r <= col1_r;

      c_r[0] <= CRW'(p_r[0]) - CRW'(p_r[1]);
      c_r[1] <= CRW'(p_r[2]) - CRW'(p_r[3]);
      c_r[2] <= CRW'(p_r[4]) - CRW'(p_r[5]);
      d3_r   <= d2_r;
      col3_r <= col2_r;

      hh_r   <= hh_nxt;
      hl_r   <= hl_nxt;
      ll_r   <= ll_nxt;
      dh_r   <= dh_nxt;
      dl_r   <= dl_nxt;
      czn4_r <= c_r[2][CRW-1];
      col4_r <= col3_r;

      s_r    <= s_nxt;
      sz_r   <= sq[2];
      dot_r  <= dot_nxt;
      czn5_r <= czn4_r;
      col5_r <= col4_r;
    end
  end

endmodule

FILE: sv/tbcfs_queue.sv
// Short queue that decouples the classifying front from the shading back.
module tbcfs_queue (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    push_i,
  input  tbcfs_pkg::tbcfs_entry_t din_i,
  input  logic                    pop_i,
  output tbcfs_pkg::tbcfs_entry_t dout_o,
  output logic                    full_o,
  output logic                    empty_o
);

  localparam int DEPTH = tbcfs_pkg::QDEPTH;
  localparam int QAW   = tbcfs_pkg::QAW;
  localparam int QCW   = QAW + 1;

  tbcfs_pkg::tbcfs_entry_t mem_r [DEPTH];
  logic [QAW-1:0] wr_ptr_r;
  logic [QAW-1:0] rd_ptr_r;
  logic [QCW-1:0] count_r;

  assign full_o  = (count_r == QCW'(DEPTH));
  assign empty_o = (count_r == '0);
  assign dout_o  = mem_r[rd_ptr_r];

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_r <= count_r + 1'b1;
      end else if (pop_i && !push_i) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  // Store entries
  always_ff @(posedge clk) begin
    if (push_i) begin
      mem_r[wr_ptr_r] <= din_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push_i |-> !full_o)
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop_i |-> !empty_o)
    else $error("queue pop while empty");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (push_i && !pop_i) |=> (count_r != '0) && (count_r <= QCW'(DEPTH)))
    else $error("queue occupancy out of range");

endmodule

FILE: sv/tbcfs_back.sv
// Back pipeline: quotient of squares, square root digit by digit, channel scaling.
module tbcfs_back (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    q_empty,
  input  tbcfs_pkg::tbcfs_entry_t q_entry,
  output logic                    q_pop,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic                    out_visible,
  output logic [31:0]             out_shaded_color
);

  localparam int F   = tbcfs_pkg::FRAC_BITS;
  localparam int SW  = tbcfs_pkg::SW;
  localparam int QW  = tbcfs_pkg::QW;
  localparam int RW  = tbcfs_pkg::RW;
  localparam int SQW = tbcfs_pkg::SQW;
  localparam int XW  = tbcfs_pkg::XW;
  localparam int PRW = RW + 8;

  typedef struct packed {
    logic          vis;
    logic          shade;
    logic [SW-1:0] s;
    logic [SW-1:0] rem;
    logic [QW-1:0] quo;
    logic [XW-1:0] color;
  } dv_t;

  typedef struct packed {
    logic           vis;
    logic           shade;
    logic [QW-1:0]  quo;
    logic [RW-1:0]  root;
    logic [SQW-1:0] sq;
    logic [XW-1:0]  color;
  } sr_t;

  logic en;
  logic [QW:0] bv_r;
  logic [RW:0] sv_r;
  dv_t dv_r   [QW+1];
  dv_t dv_nxt [QW+1];
  sr_t sr_r   [RW+1];
  sr_t sr_nxt [RW+1];
  logic [SW-1:0]  dt  [QW];
  logic           dge [QW];
  logic [SQW-1:0] st  [RW];
  logic           sge [RW];

  sr_t            fin;
  logic [RW-1:0]  qf;
  logic [PRW-1:0] pr_r;
  logic [PRW-1:0] pr_g;
  logic [PRW-1:0] pr_b;
  logic           out_valid_r;
  logic           out_visible_r;
  logic [XW-1:0]  out_color_r;

  // Advance unless a finished item waits at the output
  assign en        = !out_valid_r || out_ready;
  assign q_pop     = en && !q_empty;
  assign out_valid        = out_valid_r;
  assign out_visible      = out_visible_r;
  assign out_shaded_color = out_color_r;

  // Restoring division: one quotient bit per stage, remainder stays below s
  always_comb begin
    dv_nxt[0].vis   = q_entry.vis;
    dv_nxt[0].shade = q_entry.shade;
    dv_nxt[0].s     = q_entry.s;
    dv_nxt[0].rem   = q_entry.sz;
    dv_nxt[0].quo   = '0;
    dv_nxt[0].color = q_entry.color;
    for (int k = 0; k < QW; k++) begin
      dt[k]           = (k == 0) ? dv_r[k].rem : (dv_r[k].rem << 1);
      dge[k]          = (dt[k] >= dv_r[k].s);
      dv_nxt[k+1]     = dv_r[k];
      dv_nxt[k+1].rem = dge[k] ? (dt[k] - dv_r[k].s) : dt[k];
      dv_nxt[k+1].quo = {dv_r[k].quo[QW-2:0], dge[k]};
    end
  end

  // Integer square root: try one root bit per stage, track the root's square
  always_comb begin
    int b;
    sr_nxt[0].vis   = dv_r[QW].vis;
    sr_nxt[0].shade = dv_r[QW].shade;
    sr_nxt[0].quo   = dv_r[QW].quo;
    sr_nxt[0].root  = '0;
    sr_nxt[0].sq    = '0;
    sr_nxt[0].color = dv_r[QW].color;
    for (int j = 0; j < RW; j++) begin
      b                = RW - 1 - j;
      st[j]            = sr_r[j].sq + (SQW'(sr_r[j].root) << (b + 1)) + (SQW'(1) << (2 * b));
      sge[j]           = (st[j] <= SQW'(sr_r[j].quo));
      sr_nxt[j+1]      = sr_r[j];
      sr_nxt[j+1].root = sr_r[j].root | (RW'(sge[j]) << b);
      sr_nxt[j+1].sq   = sge[j] ? st[j] : sr_r[j].sq;
    end
  end

  // Scale each color channel by the shade factor
  always_comb begin
    fin  = sr_r[RW];
    qf   = fin.shade ? fin.root : '0;
    pr_r = PRW'(fin.color[23:16]) * PRW'(qf);
    pr_g = PRW'(fin.color[15:8]) * PRW'(qf);
    pr_b = PRW'(fin.color[7:0]) * PRW'(qf);
  end

  // Valid chains and output handshake
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bv_r        <= '0;
      sv_r        <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      bv_r        <= {bv_r[QW-1:0], !q_empty};
      sv_r        <= {sv_r[RW-1:0], bv_r[QW]};
      out_valid_r <= sv_r[RW];
    end
  end

  // Payload stages
  always_ff @(posedge clk) begin
    if (en) begin
      dv_r          <= dv_nxt;
      sr_r          <= sr_nxt;
      out_visible_r <= fin.vis;
      out_color_r   <= fin.vis ? {fin.color[31:24], pr_r[F+7:F], pr_g[F+7:F], pr_b[F+7:F]}
                               : '0;
    end
  end

  a_cull_black: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_visible_r) |-> (out_color_r == '0))
    else $error("culled triangle carries a color");
  // Drawn triangles always have a nonzero divisor, so their root stays within one
  a_root_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (sv_r[RW] && sr_r[RW].vis) |-> (sr_r[RW].root <= RW'(1 << F)))
    else $error("shade factor above one");
  a_pop_feeds: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> bv_r[0])
    else $error("popped item lost at back entry");

endmodule

FILE: sv/triangle_backface_cull_flat_shade_top.sv
// Top level of the triangle back-face cull and flat shade block.
// Accepts one triangle per clock while in_ready is high and returns one
// result per triangle, in order. Results pass through 5 front stages,
// the 4-entry queue, 2*FRAC_BITS+2 division stages, FRAC_BITS+2 square
// root stages and the output register. The long back pipeline (one
// quotient bit, then one root bit per stage) holds most of these stages;
// the sustained rate is one item per cycle whenever out_ready stays high.
// The user writes camera registers 0..2 through cfg_* only while idle; this
// is not enforced. Index 3 writes are ignored. cfg_ready is always high.
module triangle_backface_cull_flat_shade_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [31:0]         cfg_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic signed [31:0]  in_v0_x,
  input  logic signed [31:0]  in_v0_y,
  input  logic signed [31:0]  in_v0_z,
  input  logic signed [31:0]  in_v1_x,
  input  logic signed [31:0]  in_v1_y,
  input  logic signed [31:0]  in_v1_z,
  input  logic signed [31:0]  in_v2_x,
  input  logic signed [31:0]  in_v2_y,
  input  logic signed [31:0]  in_v2_z,
  input  logic [31:0]         in_face_color,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_visible,
  output logic [31:0]         out_shaded_color
);

  logic signed [31:0] camera_x_r;
  logic signed [31:0] camera_y_r;
  logic signed [31:0] camera_z_r;
  logic q_full;
  logic q_empty;
  logic q_push;
  logic q_pop;
  tbcfs_pkg::tbcfs_entry_t q_din;
  tbcfs_pkg::tbcfs_entry_t q_dout;

  assign cfg_ready = 1'b1;

  // Write camera registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      camera_x_r <= '0;
      camera_y_r <= '0;
      camera_z_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        tbcfs_pkg::CFG_CAMERA_X: camera_x_r <= cfg_data;
        tbcfs_pkg::CFG_CAMERA_Y: camera_y_r <= cfg_data;
        tbcfs_pkg::CFG_CAMERA_Z: camera_z_r <= cfg_data;
        default: ;
      endcase
    end
  end

  tbcfs_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_v0_x       (in_v0_x),
    .in_v0_y       (in_v0_y),
    .in_v0_z       (in_v0_z),
    .in_v1_x       (in_v1_x),
    .in_v1_y       (in_v1_y),
    .in_v1_z       (in_v1_z),
    .in_v2_x       (in_v2_x),
    .in_v2_y       (in_v2_y),
    .in_v2_z       (in_v2_z),
    .in_face_color (in_face_color),
    .cam_x         (camera_x_r),
    .cam_y         (camera_y_r),
    .cam_z         (camera_z_r),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_entry       (q_din)
  );

  tbcfs_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (q_push),
    .din_i   (q_din),
    .pop_i   (q_pop),
    .dout_o  (q_dout),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  tbcfs_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_empty          (q_empty),
    .q_entry          (q_dout),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_visible      (out_visible),
    .out_shaded_color (out_shaded_color)
  );

endmodule
